@@ rtl/no_leap_date_advance_assert.svh @@
// Assertion macros shared by the date keeper checker.
// Depends on nothing; the including module supplies the clock and reset names.
`ifndef NO_LEAP_DATE_ADVANCE_ASSERT_SVH
`define NO_LEAP_DATE_ADVANCE_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define NLDA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checks an implication on every rising clock edge outside reset.
`define NLDA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/nlda_pkg.sv @@
// Package for the 365-day date keeper: widths, item types and month tables.
// Used by every module of the block; depends on nothing.
`default_nettype none

package nlda_pkg;

    localparam int unsigned COUNT_BITS    = 24;
    localparam int unsigned YEAR_W        = 16;
    localparam int unsigned MONTH_W       = 4;
    localparam int unsigned DAY_W         = 5;
    localparam int unsigned REM_W         = 9;
    localparam int unsigned DOY_W         = 9;
    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned MONTHS        = 12;

    // The reciprocal of 365 is scaled by 2^32 and rounded down, so the estimated
    // quotient is at most one below the true one.
    localparam int unsigned        RECIP_SHIFT = 32;
    localparam longint unsigned    RECIP_MUL   = (64'd1 << RECIP_SHIFT) / DAYS_PER_YEAR;
    localparam int unsigned        RECIP_W     = $clog2(RECIP_MUL + 1);
    localparam int unsigned        PROD_W      = COUNT_BITS + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_K     = RECIP_W'(RECIP_MUL);

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    typedef logic [REM_W:0] rem_ext_t;

    typedef struct packed {
        logic                          req_type;
        logic [MONTH_W-1:0]            month_in;
        logic [DAY_W-1:0]              day_in;
        logic signed [YEAR_W-1:0]      year_in;
        logic signed [COUNT_BITS-1:0]  day_count;
    } in_item_t;

    typedef struct packed {
        logic [MONTH_W-1:0]       month_out;
        logic [DAY_W-1:0]         day_out;
        logic signed [YEAR_W-1:0] year_out;
        logic [DOY_W-1:0]         day_of_year;
        logic                     bad_date;
    } out_item_t;

    // Month codes outside 1 to 12 count as 31-day months.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] n;
        unique case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

@@ rtl/no_leap_date_advance.sv @@
// Load item: the state moves to the finish step, which registers the result and returns s_ready.
// Advance item: the divider splits the day count by 365 into years and days, then the month walk
// steps one month at a time until the days fit, then the finish step registers the result.
// One item at a time; s_ready returns once the result enters the output register, which
// waits while an earlier result is still held there.
// Synchronous active-low reset sets the date to January 1 of year 0.
`default_nettype none

module no_leap_date_advance
    import nlda_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [YEAR_W-1:0]     cur_year_reg, cur_year_next;
    logic [MONTH_W-1:0]    cur_month_reg, cur_month_next;
    logic [DAY_W-1:0]      cur_day_reg, cur_day_next;
    logic [YEAR_W-1:0]     wk_year_reg, wk_year_next;
    logic [MONTH_W-1:0]    wk_month_reg, wk_month_next;
    logic [REM_W-1:0]      wk_day_reg, wk_day_next;
    logic                  bad_reg, bad_next;
    logic                  neg_reg, neg_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_item_reg, m_item_next;

    logic                  div_start;
    logic [COUNT_BITS-1:0] div_dividend;
    logic                  div_done;
    logic [COUNT_BITS-1:0] div_quot;
    logic [REM_W-1:0]      div_rem;

    logic                  accept;
    logic                  load_ok;
    logic [DAY_W-1:0]      load_len;
    logic [YEAR_W-1:0]     quot_year;
    logic [YEAR_W-1:0]     year_add;
    logic [REM_W-1:0]      rest_days;
    logic [REM_W-1:0]      walk_len;
    logic                  out_free;

    nlda_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        load_len = month_len(s_item.month_in);
        load_ok  = (s_item.month_in >= MONTH_W'(1)) && (s_item.month_in <= MONTH_W'(MONTHS))
                   && (s_item.day_in != '0) && (s_item.day_in <= load_len);
        div_dividend = s_item.day_count[COUNT_BITS-1] ? (~s_item.day_count + 1'b1)
                                                      : s_item.day_count;
        div_start    = accept && (s_item.req_type == REQ_ADVANCE);

        quot_year = YEAR_W'(div_quot);
        if (neg_reg && (div_rem != '0)) begin
            year_add  = ~quot_year;
            rest_days = REM_W'(DAYS_PER_YEAR) - div_rem;
        end else if (neg_reg) begin
            year_add  = ~quot_year + 1'b1;
            rest_days = '0;
        end else begin
            year_add  = quot_year;
            rest_days = div_rem;
        end
        walk_len = REM_W'(month_len(wk_month_reg));

        state_next     = state_reg;
        cur_year_next  = cur_year_reg;
        cur_month_next = cur_month_reg;
        cur_day_next   = cur_day_reg;
        wk_year_next   = wk_year_reg;
        wk_month_next  = wk_month_reg;
        wk_day_next    = wk_day_reg;
        bad_next       = bad_reg;
        neg_next       = neg_reg;
        m_item_next    = m_item_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    neg_next = s_item.day_count[COUNT_BITS-1];
                    if (s_item.req_type == REQ_ADVANCE) begin
                        bad_next   = 1'b0;
                        state_next = ST_DIV;
                    end else if (load_ok) begin
                        bad_next      = 1'b0;
                        wk_year_next  = s_item.year_in;
                        wk_month_next = s_item.month_in;
                        wk_day_next   = REM_W'(s_item.day_in);
                        state_next    = ST_FIN;
                    end else begin
                        bad_next      = 1'b1;
                        wk_year_next  = cur_year_reg;
                        wk_month_next = cur_month_reg;
                        wk_day_next   = REM_W'(cur_day_reg);
                        state_next    = ST_FIN;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    wk_year_next  = cur_year_reg + year_add;
                    wk_month_next = cur_month_reg;
                    wk_day_next   = rest_days + REM_W'(cur_day_reg);
                    state_next    = ST_WALK;
                end
            end
            ST_WALK: begin
                if (wk_day_reg > walk_len) begin
                    wk_day_next = wk_day_reg - walk_len;
                    if ((wk_month_reg >= MONTH_W'(MONTHS)) || (wk_month_reg == '0)) begin
                        wk_month_next = MONTH_W'(1);
                        wk_year_next  = wk_year_reg + 1'b1;
                    end else begin
                        wk_month_next = wk_month_reg + 1'b1;
                    end
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cur_year_next           = wk_year_reg;
                    cur_month_next          = wk_month_reg;
                    cur_day_next            = DAY_W'(wk_day_reg);
                    m_item_next.month_out   = wk_month_reg;
                    m_item_next.day_out     = DAY_W'(wk_day_reg);
                    m_item_next.year_out    = wk_year_reg;
                    m_item_next.day_of_year = days_before(wk_month_reg) + wk_day_reg;
                    m_item_next.bad_date    = bad_reg;
                    m_valid_next            = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_year_reg  <= '0;
            cur_month_reg <= MONTH_W'(1);
            cur_day_reg   <= DAY_W'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_year_reg  <= cur_year_next;
            cur_month_reg <= cur_month_next;
            cur_day_reg   <= cur_day_next;
            m_valid_reg   <= m_valid_next;
        end
        wk_year_reg  <= wk_year_next;
        wk_month_reg <= wk_month_next;
        wk_day_reg   <= wk_day_next;
        bad_reg      <= bad_next;
        neg_reg      <= neg_next;
        m_item_reg   <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

@@ rtl/nlda_div.sv @@
// Division of an unsigned day count by 365 with a reciprocal multiply and one correction.
// Depends on nlda_pkg; done pulses once the multiply, subtract and fix steps have each been registered.
`default_nettype none

module nlda_div
    import nlda_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [COUNT_BITS-1:0] dividend,
    output logic                       done,
    output logic [COUNT_BITS-1:0]      quot,
    output logic [REM_W-1:0]           rem
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_SUB  = 2'd2;
    localparam logic [1:0] PH_FIX  = 2'd3;

    logic [1:0]            phase_reg, phase_next;
    logic [COUNT_BITS-1:0] x_reg, x_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [COUNT_BITS-1:0] q_reg, q_next;
    rem_ext_t              r_reg, r_next;
    logic [COUNT_BITS-1:0] quot_reg, quot_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic                  done_reg, done_next;
    logic [COUNT_BITS-1:0] q_est;
    logic [COUNT_BITS-1:0] diff;
    logic                  fits;

    always_comb begin
        q_est      = COUNT_BITS'(prod_reg[PROD_W-1:RECIP_SHIFT]);
        diff       = x_reg - q_est * COUNT_BITS'(DAYS_PER_YEAR);
        fits       = r_reg >= rem_ext_t'(DAYS_PER_YEAR);
        phase_next = phase_reg;
        x_next     = x_reg;
        prod_next  = prod_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        done_next  = 1'b0;
        if (start) begin
            x_next     = dividend;
            phase_next = PH_MUL;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    phase_next = PH_IDLE;
                end
                PH_MUL: begin
                    prod_next  = PROD_W'(x_reg) * PROD_W'(RECIP_K);
                    phase_next = PH_SUB;
                end
                PH_SUB: begin
                    q_next     = q_est;
                    r_next     = diff[REM_W:0];
                    phase_next = PH_FIX;
                end
                PH_FIX: begin
                    quot_next  = fits ? (q_reg + 1'b1) : q_reg;
                    rem_next   = fits ? REM_W'(r_reg - rem_ext_t'(DAYS_PER_YEAR))
                                      : r_reg[REM_W-1:0];
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        x_reg    <= x_next;
        prod_reg <= prod_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

@@ rtl/nlda_checker.sv @@
// Port-level checker for the date keeper, bound to the top level.
// Depends on nlda_pkg and the assertion macros in no_leap_date_advance_assert.svh.
`default_nettype none
`include "no_leap_date_advance_assert.svh"

module nlda_checker
    import nlda_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_item,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_item
);

    `NLDA_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_item), "result item changed while stalled")
    `NLDA_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "second item taken while busy")
    `NLDA_ASSERT_IMP(a_month_range, m_valid, (m_item.month_out >= 4'd1) && (m_item.month_out <= 4'd12), "month out of range")
    `NLDA_ASSERT_IMP(a_day_range, m_valid, (m_item.day_out >= 5'd1) && (m_item.day_out <= month_len(m_item.month_out)) && (m_item.day_of_year == days_before(m_item.month_out) + 9'(m_item.day_out)), "day or day of year inconsistent")

endmodule

bind no_leap_date_advance nlda_checker u_nlda_checker (.*);

`default_nettype wire
